/* sv/lru_pkg.sv */
// Shared constants for the LRU page reference tracker.
// No dependencies; lru_if, lru_ctrl, the tracker unit and the testbench import or use this package.
`default_nettype none

package lru_pkg;

  // Default sizing of the key space and of the recency list
  localparam int KEY_SPACE_DEF  = 64;
  localparam int MAX_FRAMES_DEF = 8;

  // Frame limit register
  localparam int              CFG_W     = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

endpackage

`default_nettype wire

/* sv/lru_if.sv */
// Valid/ready channel interfaces for the LRU page reference tracker.
// Depends on lru_pkg for the width of the frame limit register.
`default_nettype none

interface lru_in_if #(
  parameter int KW = 6
);
  logic          valid;
  logic          ready;
  logic [KW-1:0] page_key;

  modport source (output valid, output page_key, input ready);
  modport sink   (input valid, input page_key, output ready);
endinterface

interface lru_out_if #(
  parameter int KW = 6,
  parameter int CW = 4
);
  logic          valid;
  logic          ready;
  logic          hit;
  logic          evicted;
  logic [KW-1:0] evicted_key;
  logic [CW-1:0] occupancy;

  modport source (output valid, output hit, output evicted, output evicted_key,
                  output occupancy, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_key,
                  input occupancy, output ready);
endinterface

interface lru_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lru_pkg::CFG_W-1:0]  frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

/* sv/lru_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lru_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/lru_ctrl.sv */
// Recency list sequencer: a doubly linked list of resident keys held in two
// key-indexed RAMs (prev link with present flag, next link), head/tail pointers.
// Depends on lru_pkg and lru_ram.
`default_nettype none

module lru_ctrl #(
  parameter  int KEY_SPACE  = lru_pkg::KEY_SPACE_DEF,
  parameter  int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  localparam int KW         = $clog2(KEY_SPACE),
  localparam int CW         = $clog2(MAX_FRAMES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [KW-1:0]             in_key,
  input  wire logic [lru_pkg::CFG_W-1:0] frames_in_use,
  output logic                           res_valid,
  input  wire logic                      res_take,
  output logic                           res_hit,
  output logic                           res_evicted,
  output logic [KW-1:0]                  res_evicted_key,
  output logic [CW-1:0]                  res_occupancy
);
  import lru_pkg::*;

  localparam int         LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [KW:0] KS = (KW + 1)'(KEY_SPACE);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_EVICT = 7'b0000100,
    S_INS   = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_LINK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [KW-1:0]   head_r, head_nxt;
  logic [KW-1:0]   tail_r, tail_nxt;
  logic [KW-1:0]   p_r, p_nxt;
  logic [KW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            hit_r, hit_nxt;
  logic            ev_r, ev_nxt;
  logic [KW-1:0]   evk_r, evk_nxt;
  logic [KEY_SPACE-1:0] vld_r;

  // prev RAM entry: {present, prev link}
  logic            prev_we;
  logic [KW-1:0]   prev_waddr, prev_raddr;
  logic [KW:0]     prev_wdata, prev_rdata;
  logic            next_we;
  logic [KW-1:0]   next_waddr, next_raddr, next_wdata, next_rdata;

  logic [KW:0]     key_ext;
  logic [KW-1:0]   key_red;
  logic [LW-1:0]   lim_raw, lim;
  logic            present;
  logic            evict_now;

  lru_ram #(.WIDTH(KW + 1), .DEPTH(KEY_SPACE)) u_prev_ram (
    .clk       (clk),
    .we        (prev_we),
    .wr_addr   (prev_waddr),
    .wr_data   (prev_wdata),
    .rd_addr   (prev_raddr),
    .rd_data_r (prev_rdata)
  );

  lru_ram #(.WIDTH(KW), .DEPTH(KEY_SPACE)) u_next_ram (
    .clk       (clk),
    .we        (next_we),
    .wr_addr   (next_waddr),
    .wr_data   (next_wdata),
    .rd_addr   (next_raddr),
    .rd_data_r (next_rdata)
  );

  // Fold keys beyond the key space back into range
  always_comb begin
    key_ext = {1'b0, in_key};
    if (key_ext >= KS) begin
      key_red = KW'(key_ext - KS);
    end else begin
      key_red = in_key;
    end
  end

  // Effective frame limit: zero acts as one, clamp to list depth
  always_comb begin
    lim_raw = LW'(frames_in_use);
    if (lim_raw == '0) begin
      lim = LW'(1);
    end else if (lim_raw > LW'(MAX_FRAMES)) begin
      lim = LW'(MAX_FRAMES);
    end else begin
      lim = lim_raw;
    end
  end

  // An entry never written since reset reads as absent
  assign present   = vld_r[key_r] & prev_rdata[KW];
  assign evict_now = (LW'(count_r) >= lim) && (count_r != '0);

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    ev_nxt     = ev_r;
    evk_nxt    = evk_r;
    prev_we    = 1'b0;
    prev_waddr = key_r;
    prev_wdata = {1'b1, key_r};
    prev_raddr = key_r;
    next_we    = 1'b0;
    next_waddr = key_r;
    next_wdata = head_r;
    next_raddr = key_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt    = key_red;
          prev_raddr = key_red;
          next_raddr = key_red;
          state_nxt  = S_LOOK;
        end
      end

      S_LOOK: begin
        hit_nxt = present;
        ev_nxt  = 1'b0;
        evk_nxt = '0;
        p_nxt   = prev_rdata[KW-1:0];
        n_nxt   = next_rdata;
        if (present) begin
          if (key_r == head_r) begin
            state_nxt = S_DONE;
          end else begin
            // unlink: prev.next <= next; old head.prev <= key
            next_we    = 1'b1;
            next_waddr = prev_rdata[KW-1:0];
            next_wdata = next_rdata;
            prev_we    = 1'b1;
            prev_waddr = head_r;
            prev_wdata = {1'b1, key_r};
            state_nxt  = S_LINK;
          end
        end else if (evict_now) begin
          prev_raddr = tail_r;
          state_nxt  = S_EVICT;
        end else begin
          state_nxt = S_INS;
        end
      end

      S_EVICT: begin
        ev_nxt     = 1'b1;
        evk_nxt    = tail_r;
        prev_we    = 1'b1;
        prev_waddr = tail_r;
        prev_wdata = {1'b0, {KW{1'b0}}};
        tail_nxt   = prev_rdata[KW-1:0];
        count_nxt  = CW'(count_r - 1'b1);
        state_nxt  = S_INS;
      end

      S_INS: begin
        if (count_r != '0) begin
          prev_we    = 1'b1;
          prev_waddr = head_r;
          prev_wdata = {1'b1, key_r};
          next_we    = 1'b1;
          next_waddr = key_r;
          next_wdata = head_r;
        end
        state_nxt = S_FIX;
      end

      S_FIX: begin
        prev_we    = 1'b1;
        prev_waddr = key_r;
        prev_wdata = {1'b1, {KW{1'b0}}};
        head_nxt   = key_r;
        if (count_r == '0) begin
          tail_nxt = key_r;
        end
        if (count_r < CW'(MAX_FRAMES)) begin
          count_nxt = CW'(count_r + 1'b1);
        end
        state_nxt = S_DONE;
      end

      S_LINK: begin
        next_we    = 1'b1;
        next_waddr = key_r;
        next_wdata = head_r;
        head_nxt   = key_r;
        if (key_r == tail_r) begin
          tail_nxt = p_r;
        end else begin
          prev_we    = 1'b1;
          prev_waddr = n_r;
          prev_wdata = {1'b1, p_r};
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      if (prev_we) begin
        vld_r[prev_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    p_r   <= p_nxt;
    n_r   <= n_nxt;
    hit_r <= hit_nxt;
    ev_r  <= ev_nxt;
    evk_r <= evk_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res_hit         = hit_r;
  assign res_evicted     = ev_r;
  assign res_evicted_key = evk_r;
  assign res_occupancy   = count_r;

endmodule

`default_nettype wire

/* sv/lru_page_reference_tracker_unit.sv */
// LRU page reference tracker: one result beat per page reference.
// Each reference is looked up, then relinked to the head on a hit away from the head,
// or inserted and fixed up on a miss, after an eviction step when the list is full;
// one reference is in flight at a time, set by the read-modify-write sequence on the link RAMs.
// Synchronous active-low reset empties the list, clears all presence valid bits
// and sets the frame limit to 4; no clearing pass is needed.
`default_nettype none

module lru_page_reference_tracker_unit #(
  parameter  int KEY_SPACE  = lru_pkg::KEY_SPACE_DEF,
  parameter  int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  localparam int KW         = $clog2(KEY_SPACE),
  localparam int CW         = $clog2(MAX_FRAMES + 1)
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lru_in_if.sink     in_if,
  lru_out_if.source  out_if,
  lru_cfg_if.sink    cfg_if
);
  import lru_pkg::*;

  logic [CFG_W-1:0] frames_r;
  logic             res_valid;
  logic             res_take;
  logic             res_hit;
  logic             res_evicted;
  logic [KW-1:0]    res_evicted_key;
  logic [CW-1:0]    res_occupancy;

  logic             out_valid_r;
  logic             hit_r;
  logic             evicted_r;
  logic [KW-1:0]    evicted_key_r;
  logic [CW-1:0]    occupancy_r;

  lru_ctrl #(
    .KEY_SPACE  (KEY_SPACE),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_key          (in_if.page_key),
    .frames_in_use   (frames_r),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res_hit         (res_hit),
    .res_evicted     (res_evicted),
    .res_evicted_key (res_evicted_key),
    .res_occupancy   (res_occupancy)
  );

  // Frame limit register
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_RESET;
    end else if (cfg_if.valid) begin
      frames_r <= cfg_if.frames_in_use;
    end
  end

  // Output register: load when empty or draining this cycle
  assign res_take = res_valid && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      hit_r         <= res_hit;
      evicted_r     <= res_evicted;
      evicted_key_r <= res_evicted_key;
      occupancy_r   <= res_occupancy;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.hit         = hit_r;
  assign out_if.evicted     = evicted_r;
  assign out_if.evicted_key = evicted_key_r;
  assign out_if.occupancy   = occupancy_r;

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for lru_page_reference_tracker_unit: page references in, hit/evict results out.
// Depends on lru_pkg and the channel interfaces in lru_if; a shadow LRU list predicts each result.

module testbench;

  import lru_pkg::*;

  localparam int KEY_SPACE  = KEY_SPACE_DEF;
  localparam int MAX_FRAMES = MAX_FRAMES_DEF;
  localparam int KW         = $clog2(KEY_SPACE);
  localparam int CW         = $clog2(MAX_FRAMES + 1);
  localparam int SETTLE     = 8;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASE_REFS = 150;

  typedef struct packed {
    logic          hit;
    logic          evicted;
    logic [KW-1:0] evicted_key;
    logic [CW-1:0] occupancy;
  } ref_outcome_t;

  class lru_tracker_check;
    bit           present[KEY_SPACE];
    logic [KW-1:0] recency[MAX_FRAMES];
    int unsigned  resident;
    logic [CFG_W-1:0] frames;
    ref_outcome_t pending_outcomes[$];
    int           errors;
    int           refs_seen;
    int           hits;
    int           evictions;
    int           limit_writes;

    function new();
      foreach (present[i]) present[i] = 1'b0;
      foreach (recency[i]) recency[i] = '0;
      resident     = 0;
      frames       = CFG_RESET;
      errors       = 0;
      refs_seen    = 0;
      hits         = 0;
      evictions    = 0;
      limit_writes = 0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] v);
      frames = v;
      limit_writes++;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    // Shift entries 0..upto-1 one place toward the tail, put key at the head.
    function void move_to_head(int unsigned upto, logic [KW-1:0] key);
      if (upto >= MAX_FRAMES) upto = MAX_FRAMES - 1;
      for (int i = upto; i > 0; i--) recency[i] = recency[i-1];
      recency[0] = key;
    endfunction

    function void note_ref(logic [KW-1:0] key);
      ref_outcome_t r;
      int unsigned  pos;
      int unsigned  lim;
      int unsigned  tail;
      r = '0;
      lim = (frames == 0) ? 1 : ((frames > MAX_FRAMES) ? MAX_FRAMES : frames);
      if (present[key]) begin
        r.hit = 1'b1;
        pos = 0;
        // scan from the tail so the match nearest the head wins
        for (int i = int'(resident) - 1; i >= 0; i--) begin
          if (i < MAX_FRAMES && recency[i] == key) pos = i;
        end
        move_to_head(pos, key);
        hits++;
      end else begin
        if (resident >= lim && resident > 0) begin
          tail = resident - 1;
          if (tail >= MAX_FRAMES) tail = MAX_FRAMES - 1;
          r.evicted     = 1'b1;
          r.evicted_key = recency[tail];
          present[recency[tail]] = 1'b0;
          resident--;
          evictions++;
        end
        move_to_head(resident, key);
        present[key] = 1'b1;
        if (resident < MAX_FRAMES) resident++;
      end
      r.occupancy = CW'(resident);
      refs_seen++;
      pending_outcomes.push_back(r);
    endfunction

    function void field_diff(string name, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ref_outcome_t got);
      ref_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual hit=%0d evicted=%0d key=%0d occ=%0d",
                 $time, got.hit, got.evicted, got.evicted_key, got.occupancy);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      field_diff("hit", int'(want.hit), int'(got.hit));
      field_diff("evicted", int'(want.evicted), int'(got.evicted));
      field_diff("evicted_key", int'(want.evicted_key), int'(got.evicted_key));
      field_diff("occupancy", int'(want.occupancy), int'(got.occupancy));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lru_in_if  #(.KW(KW))           in_ch ();
  lru_out_if #(.KW(KW), .CW(CW))  out_ch ();
  lru_cfg_if                      cfg_ch ();

  lru_page_reference_tracker_unit #(
    .KEY_SPACE  (KEY_SPACE),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #4 clk = ~clk;

  lru_tracker_check tracker;

  // beat monitor: check results, then feed accepted references and limit writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_result({out_ch.hit, out_ch.evicted, out_ch.evicted_key, out_ch.occupancy});
      if (in_ch.valid && in_ch.ready)
        tracker.note_ref(in_ch.page_key);
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.set_frames(cfg_ch.frames_in_use);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                 $time, QUIET_MAX, tracker.pending());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result-side backpressure: ready follows a randomly drawn 16-bit mask, whose bit 0 is always set
  logic [15:0] ready_mask;
  int unsigned ready_tick = 0;

  always @(posedge clk) begin
    if (ready_tick % 97 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_mask = '1;
        1:       ready_mask = 16'($urandom);
        2:       ready_mask = 16'($urandom | $urandom);
        default: ready_mask = 16'($urandom & $urandom);
      endcase
      ready_mask[0] = 1'b1;
    end
    out_ch.ready <= ready_mask[ready_tick % 16];
    ready_tick++;
  end

  int burst_left = 0;
  bit gapless    = 1'b0;

  task automatic send_ref(input logic [KW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.page_key <= key;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off new references until every outstanding result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    drain();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.frames_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] limits[12];
    int unsigned base;
    int unsigned span;
    logic [KW-1:0] key;

    limits               = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5,
                             4'd2, 4'd9, 4'd6, 4'd4, 4'd7, 4'd8};
    tracker              = new();
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.page_key       = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.frames_in_use = '0;
    out_ch.ready         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of four: cold misses, hit at head, hit further down, first eviction
    send_ref(6'd0);  send_ref(6'd63); send_ref(6'd63); send_ref(6'd0);
    send_ref(6'd21); send_ref(6'd42); send_ref(6'd7);  send_ref(6'd63);

    // widest list, then shrink the limit under the current occupancy
    write_frames(4'd8);
    send_ref(6'd10); send_ref(6'd11); send_ref(6'd12); send_ref(6'd13); send_ref(6'd14);
    write_frames(4'd2);
    send_ref(6'd50); send_ref(6'd11); send_ref(6'd51);

    // zero limit acts as one; oversize limits clamp to the list depth
    write_frames(4'd0);
    send_ref(6'd5);  send_ref(6'd5);  send_ref(6'd6);
    write_frames(4'd15);
    send_ref(6'd30); send_ref(6'd31);
    write_frames(4'd9);
    send_ref(6'd32);

    // random part: mostly a small working set near the limit, some keys from anywhere
    foreach (limits[p]) begin
      write_frames(limits[p]);
      gapless = (p % 3 == 0);
      base = $urandom_range(0, KEY_SPACE - 1);
      span = $urandom_range(2, 12);
      for (int n = 0; n < PHASE_REFS; n++) begin
        if ($urandom_range(0, 9) < 7)
          key = KW'((base + $urandom_range(0, span - 1)) % KEY_SPACE);
        else
          key = KW'($urandom_range(0, KEY_SPACE - 1));
        send_ref(key);
        if (p == 5 && n == PHASE_REFS / 2) drain();
      end
    end

    drain();
    $display("Covered %0d page references over %0d frame-limit settings: %0d hits, %0d evictions.",
             tracker.refs_seen, tracker.limit_writes, tracker.hits, tracker.evictions);
    $display("Field mismatches: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
